// ----- hw/rtl/lmfc_pkg.sv -----
// ----------------------------------------------------------------------------
// LCS motif frequency counter package
// Shared constants, codes and types for the motif counter modules.
// ----------------------------------------------------------------------------
package lmfc_pkg;

  localparam int MAX_MOTIFS = 64;
  localparam int MAX_WINDOW = 16;
  localparam int COUNT_BITS = 16;

  localparam int IDX_W  = $clog2(MAX_MOTIFS);
  localparam int TOT_W  = IDX_W + 1;
  localparam int POS_W  = $clog2(MAX_WINDOW);
  localparam int LEN_W  = POS_W + 1;
  localparam int ADDR_W = IDX_W + POS_W;
  localparam int BASE_W = 8;
  localparam int CUT_W  = 16;
  localparam int CFG_W  = 16;

  // Operation codes of an input transaction.
  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_SEQ  = 2'd1,
    OP_READ = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  // Result kinds of an output transaction.
  typedef enum logic [1:0] {
    KIND_MATCH = 2'd0,
    KIND_ADDED = 2'd1,
    KIND_DROP  = 2'd2,
    KIND_READ  = 2'd3
  } kind_t;

  // Configuration register indexes.
  typedef enum logic {
    CFG_WINDOW_LEN = 1'b0,
    CFG_CUT_OFF    = 1'b1
  } cfg_idx_t;

  // One queued input item.
  typedef struct packed {
    op_t               op;
    logic [BASE_W-1:0] base;
    logic [IDX_W-1:0]  slot;
    logic              last;
  } item_t;

  typedef logic [MAX_WINDOW-1:0][BASE_W-1:0] win_t;
  typedef logic [MAX_WINDOW-1:0][LEN_W-1:0]  row_t;

endpackage

// ----- hw/rtl/lmfc_front.sv -----
// ----------------------------------------------------------------------------
// LCS motif counter front end
// Accepts input transactions, decodes them into items and queues them.
// ----------------------------------------------------------------------------
module lmfc_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [15:0]               s_tdata,   // base[7:0], slot[13:8], zero[15:14]
  input  logic [1:0]                s_tuser,   // operation[1:0]
  input  logic                      s_tlast,
  output logic                      q_valid,
  output lmfc_pkg::item_t           q_item,
  input  logic                      q_pop
);

  lmfc_pkg::item_t entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;
  lmfc_pkg::item_t in_item;

  // Decode the incoming transaction into an item.
  always_comb begin
    in_item.op   = lmfc_pkg::op_t'(s_tuser);
    in_item.base = s_tdata[7:0];
    in_item.slot = s_tdata[13:8];
    in_item.last = s_tlast;
  end

  assign s_tready = (fill != 2'd2);
  assign push     = s_tvalid && s_tready;
  assign q_valid  = (fill != 2'd0);
  assign q_item   = entry[rd_ptr];

  // Two-entry queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= in_item;
    end
  end

  // Queue pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, q_pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ----- hw/rtl/lmfc_lcs_array.sv -----
// ----------------------------------------------------------------------------
// LCS cell array
// One cell per window column; motif bases flow through as a wavefront.
// ----------------------------------------------------------------------------
module lmfc_lcs_array (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          clear,
  input  logic                          in_v,
  input  logic [lmfc_pkg::BASE_W-1:0]   in_base,
  input  lmfc_pkg::win_t                window,
  output lmfc_pkg::row_t                rows
);

  localparam int MW = lmfc_pkg::MAX_WINDOW;
  localparam int LW = lmfc_pkg::LEN_W;

  lmfc_pkg::row_t row_q;
  lmfc_pkg::row_t prv_q;
  lmfc_pkg::row_t left;
  lmfc_pkg::row_t diag;
  lmfc_pkg::row_t row_n;
  lmfc_pkg::win_t a_sh;
  lmfc_pkg::win_t a_in;
  logic [MW-1:0]  v_sh;
  logic [MW-1:0]  v_in;

  // Neighbor wiring: cell zero sees the memory and a zero boundary.
  for (genvar j = 0; j < MW; j++) begin : g_link
    if (j == 0) begin : g_first
      assign a_in[j] = in_base;
      assign v_in[j] = in_v;
      assign left[j] = '0;
      assign diag[j] = '0;
    end else begin : g_rest
      assign a_in[j] = a_sh[j-1];
      assign v_in[j] = v_sh[j-1];
      assign left[j] = row_q[j-1];
      assign diag[j] = prv_q[j-1];
    end
  end

  // Cell update: match extends the diagonal, otherwise keep the larger.
  always_comb begin
    for (int j = 0; j < MW; j++) begin
      if (a_in[j] == window[j]) begin
        row_n[j] = diag[j] + LW'(1);
      end else if (left[j] > row_q[j]) begin
        row_n[j] = left[j];
      end else begin
        row_n[j] = row_q[j];
      end
    end
  end

  // Row values, previous rows and the base shift line.
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      row_q <= '0;
      prv_q <= '0;
      v_sh  <= '0;
    end else begin
      v_sh <= v_in;
      for (int j = 0; j < MW; j++) begin
        if (v_in[j]) begin
          row_q[j] <= row_n[j];
          prv_q[j] <= row_q[j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    a_sh <= a_in;
  end

  assign rows = row_q;

endmodule

// ----- hw/rtl/lmfc_back.sv -----
// ----------------------------------------------------------------------------
// LCS motif counter back end
// Executes queued items: motif loads, count reads and window scoring.
// ----------------------------------------------------------------------------
module lmfc_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [4:0]                    window_len,
  input  logic [lmfc_pkg::CUT_W-1:0]    cut_off,
  input  logic                          q_valid,
  input  lmfc_pkg::item_t               q_item,
  output logic                          q_pop,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [31:0]                   m_tdata,  // motif_index[5:0], count[21:6],
                                                  // lcs_length[26:22], slot_valid[27]
  output logic [1:0]                    m_tuser   // result_kind[1:0]
);

  localparam int MM = lmfc_pkg::MAX_MOTIFS;
  localparam int MW = lmfc_pkg::MAX_WINDOW;
  localparam int IW = lmfc_pkg::IDX_W;
  localparam int TW = lmfc_pkg::TOT_W;
  localparam int PW = lmfc_pkg::POS_W;
  localparam int LW = lmfc_pkg::LEN_W;
  localparam int AW = lmfc_pkg::ADDR_W;
  localparam int BW = lmfc_pkg::BASE_W;
  localparam int CW = lmfc_pkg::COUNT_BITS;
  localparam int TH_W = lmfc_pkg::CUT_W + LW;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCORE = 6'b000010,
    S_FIN   = 6'b000100,
    S_CNT   = 6'b001000,
    S_RDC   = 6'b010000,
    S_COPY  = 6'b100000
  } state_t;

  state_t state;
  logic [TW-1:0] total;
  logic [LW-1:0] lp;
  logic [LW-1:0] fill;
  lmfc_pkg::win_t wbuf;
  logic [LW-1:0] n_len;
  logic [IW-1:0] mi;
  logic [5:0]    t;
  logic [LW-1:0] best;
  logic [IW-1:0] best_idx;
  logic          found;
  logic [IW-1:0] rd_slot;

  // Result register.
  logic              o_valid;
  lmfc_pkg::kind_t   o_kind;
  logic [IW-1:0]     o_idx;
  logic [CW-1:0]     o_cnt;
  logic [LW-1:0]     o_lcs;
  logic              o_sv;

  // Motif store and count memory.
  logic [BW-1:0] store [1 << AW];
  logic          s_we;
  logic [AW-1:0] s_waddr;
  logic [BW-1:0] s_wdata;
  logic [AW-1:0] s_raddr;
  logic [BW-1:0] s_rdata;
  logic          s_rdv;

  logic [CW-1:0] cmem [MM];
  logic [MM-1:0] cvld;
  logic          c_we;
  logic [IW-1:0] c_waddr;
  logic [CW-1:0] c_wdata;
  logic [IW-1:0] c_raddr;
  logic [CW-1:0] c_rd;
  logic          c_rdv;
  logic [CW-1:0] cnt_cur;
  logic [CW-1:0] cnt_inc;

  // Scoring helpers.
  logic [LW-1:0]   len;
  logic [LW-1:0]   fill_new;
  logic            lp_room;
  logic            tbl_room;
  logic            score_tick;
  logic [LW-1:0]   col;
  logic [LW-1:0]   score;
  logic [TH_W-1:0] thr;
  logic            pass;
  logic            rd_ok;
  lmfc_pkg::row_t  rows;

  // Effective window length.
  always_comb begin
    if (window_len == 5'd0) begin
      len = LW'(1);
    end else if (LW'(window_len) > LW'(MW)) begin
      len = LW'(MW);
    end else begin
      len = LW'(window_len);
    end
  end

  assign q_pop      = (state == S_IDLE) && q_valid && !o_valid;
  assign fill_new   = (fill < LW'(MW)) ? fill + LW'(1) : fill;
  assign lp_room    = (lp < LW'(MW));
  assign tbl_room   = (total < TW'(MM));
  assign score_tick = (state == S_SCORE) && (t == 6'(len) + 6'(MW + 1));
  assign col        = n_len - LW'(1);
  assign score      = rows[col[PW-1:0]];
  assign thr        = TH_W'(cut_off) * TH_W'(len);
  assign pass       = {score, 16'd0} > thr;
  assign cnt_cur    = c_rdv ? c_rd : '0;
  assign cnt_inc    = (cnt_cur == {CW{1'b1}}) ? cnt_cur : cnt_cur + CW'(1);
  assign rd_ok      = ({1'b0, rd_slot} < total);

  // Store write and read addressing.
  always_comb begin
    s_we    = 1'b0;
    s_waddr = {total[IW-1:0], lp[PW-1:0]};
    s_wdata = q_item.base;
    if (q_pop && q_item.op == lmfc_pkg::OP_LOAD && tbl_room && lp_room) begin
      s_we = 1'b1;
    end else if (state == S_COPY) begin
      s_we    = 1'b1;
      s_waddr = {total[IW-1:0], t[PW-1:0]};
      s_wdata = wbuf[t[PW-1:0]];
    end
    s_raddr = {mi, t[PW-1:0]};
  end

  always_ff @(posedge clk) begin
    if (s_we) begin
      store[s_waddr] <= s_wdata;
    end
    s_rdata <= store[s_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_rdv <= 1'b0;
    end else begin
      s_rdv <= (state == S_SCORE) && (t < 6'(len));
    end
  end

  // Count memory with per-entry valid bits.
  always_comb begin
    c_we    = 1'b0;
    c_waddr = best_idx;
    c_wdata = cnt_inc;
    if (state == S_CNT) begin
      c_we = 1'b1;
    end else if (state == S_COPY && t == 6'(n_len - LW'(1))) begin
      c_we    = 1'b1;
      c_waddr = total[IW-1:0];
      c_wdata = CW'(1);
    end
    c_raddr = (state == S_IDLE) ? q_item.slot : best_idx;
  end

  always_ff @(posedge clk) begin
    if (c_we) begin
      cmem[c_waddr] <= c_wdata;
    end
    c_rd <= cmem[c_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cvld  <= '0;
      c_rdv <= 1'b0;
    end else begin
      c_rdv <= cvld[c_raddr];
      if (c_we) begin
        cvld[c_waddr] <= 1'b1;
      end
    end
  end

  // Window buffer.
  always_ff @(posedge clk) begin
    if (q_pop && q_item.op == lmfc_pkg::OP_SEQ && fill < LW'(MW)) begin
      wbuf[fill[PW-1:0]] <= q_item.base;
    end
  end

  // Cell array scoring one motif against the window.
  lmfc_lcs_array u_array (
    .clk     (clk),
    .rst     (rst),
    .clear   ((state == S_SCORE) && (t == 6'd0)),
    .in_v    (s_rdv),
    .in_base (s_rdata),
    .window  (wbuf),
    .rows    (rows)
  );

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      total   <= '0;
      lp      <= '0;
      fill    <= '0;
      o_valid <= 1'b0;
      found   <= 1'b0;
    end else begin
      if (o_valid && m_tready) begin
        o_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_pop) begin
            case (q_item.op)
              lmfc_pkg::OP_LOAD: begin
                if (tbl_room) begin
                  if (q_item.last) begin
                    total <= total + TW'(1);
                    lp    <= '0;
                  end else if (lp_room) begin
                    lp <= lp + LW'(1);
                  end
                end
              end
              lmfc_pkg::OP_READ: begin
                rd_slot <= q_item.slot;
                state   <= S_RDC;
              end
              lmfc_pkg::OP_SEQ: begin
                if (fill_new < len && !q_item.last) begin
                  fill <= fill_new;
                end else begin
                  fill  <= '0;
                  n_len <= (fill_new > len) ? len : fill_new;
                  mi    <= '0;
                  t     <= '0;
                  best  <= '0;
                  found <= 1'b0;
                  state <= (total == '0) ? S_FIN : S_SCORE;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_SCORE: begin
          if (score_tick) begin
            if (pass) begin
              if (!found || score > best) begin
                best     <= score;
                best_idx <= mi;
                found    <= 1'b1;
              end
            end else if (!found && score > best) begin
              best <= score;
            end
            t <= '0;
            if (TW'(mi) + TW'(1) == total) begin
              state <= S_FIN;
            end else begin
              mi <= mi + IW'(1);
            end
          end else begin
            t <= t + 6'd1;
          end
        end
        S_FIN: begin
          if (found) begin
            state <= S_CNT;
          end else if (n_len == len && tbl_room) begin
            t     <= '0;
            state <= S_COPY;
          end else begin
            o_valid <= 1'b1;
            o_kind  <= lmfc_pkg::KIND_DROP;
            o_idx   <= '0;
            o_cnt   <= '0;
            o_lcs   <= best;
            o_sv    <= 1'b0;
            state   <= S_IDLE;
          end
        end
        S_CNT: begin
          o_valid <= 1'b1;
          o_kind  <= lmfc_pkg::KIND_MATCH;
          o_idx   <= best_idx;
          o_cnt   <= cnt_inc;
          o_lcs   <= best;
          o_sv    <= 1'b1;
          state   <= S_IDLE;
        end
        S_RDC: begin
          o_valid <= 1'b1;
          o_kind  <= lmfc_pkg::KIND_READ;
          o_idx   <= rd_slot;
          o_cnt   <= rd_ok ? cnt_cur : '0;
          o_lcs   <= '0;
          o_sv    <= rd_ok;
          state   <= S_IDLE;
        end
        S_COPY: begin
          if (t == 6'(n_len - LW'(1))) begin
            o_valid <= 1'b1;
            o_kind  <= lmfc_pkg::KIND_ADDED;
            o_idx   <= total[IW-1:0];
            o_cnt   <= CW'(1);
            o_lcs   <= best;
            o_sv    <= 1'b1;
            total   <= total + TW'(1);
            lp      <= '0;
            state   <= S_IDLE;
          end else begin
            t <= t + 6'd1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_tvalid = o_valid;
  assign m_tuser  = o_kind;
  assign m_tdata  = {4'd0, o_sv, o_lcs, o_cnt, o_idx};

  // The motif table never grows past its capacity.
  a_total_cap: assert property (@(posedge clk) disable iff (rst)
    total <= TW'(MM))
    else $error("motif total above capacity");

  // Scoring only runs with at least one motif in the table.
  a_score_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCORE) |-> (total != '0))
    else $error("scoring with an empty table");

  // A new result is only produced into an empty result register.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (o_valid && !m_tready) |=> (o_valid && $stable(o_idx) && $stable(o_cnt)))
    else $error("pending result overwritten");

  // Window fill and motif load position stay within their buffers.
  a_fill_cap: assert property (@(posedge clk) disable iff (rst)
    (fill <= LW'(MW)) && (lp <= LW'(MW)))
    else $error("fill or load position out of range");

endmodule

// ----- hw/rtl/lcs_motif_frequency_counter.sv -----
// ----------------------------------------------------------------------------
// LCS motif frequency counter
// Scores sequence windows against a motif table and counts best matches.
// ----------------------------------------------------------------------------
// A count read is answered from the read state after acceptance; a load gives no
// result and leaves the back end idle. A completed window is scored against
// each stored motif in turn, the cell array sweeping it out of the store; a
// drop is then reported from the finish state, a match from the count state
// after it, and a new motif is written into the store before it is reported.
// Items run one at a time. Synchronous reset clears counts, table size and fill state.
module lcs_motif_frequency_counter (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // base[7:0], slot[13:8], zero[15:14]
  input  logic [1:0]  s_tuser,   // operation[1:0]
  input  logic        s_tlast,   // last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // motif_index[5:0], count[21:6], lcs_length[26:22],
                                 // slot_valid[27], zero[31:28]
  output logic [1:0]  m_tuser,   // result_kind[1:0]
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [15:0] cfg_data
);

  logic [4:0]  window_len;
  logic [15:0] cut_off;
  logic        q_valid;
  logic        q_pop;
  lmfc_pkg::item_t q_item;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_len <= 5'd8;
      cut_off    <= 16'd32768;
    end else if (cfg_we) begin
      case (lmfc_pkg::cfg_idx_t'(cfg_addr))
        lmfc_pkg::CFG_WINDOW_LEN: window_len <= cfg_data[4:0];
        lmfc_pkg::CFG_CUT_OFF:    cut_off    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  lmfc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  lmfc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .window_len (window_len),
    .cut_off    (cut_off),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser)
  );

endmodule
